@@ design/drp_pkg.sv @@
`timescale 1ns / 1ps
package drp_pkg;

  // Configuration register indexes
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;
  localparam logic [CfgIdxW-1:0] CfgTargetX = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgTargetY = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMissTol = 2'd2;

  // 9.8 and 2 * 9.8 in Q16.16
  localparam logic [20:0] GravQ16  = 21'd642253;
  localparam logic [20:0] Grav2Q16 = 21'd1284506;

  localparam logic [30:0] MissTolReset = 31'd65536;
  localparam logic [23:0] FtMax        = 24'hFFFFFF;

  // Last step index of each serial phase
  localparam logic [4:0] SqLast = 5'd31;
  localparam logic [4:0] RtLast = 5'd31;
  localparam logic [4:0] DvLast = 5'd29;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] height;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic               abort;
  } drp_in_t;

  typedef struct packed {
    logic        release_res;
    logic [23:0] fall_time;
    logic        no_solution;
    logic        finished;
  } drp_out_t;

  // Load and step strobes for one serial unit
  typedef struct packed {
    logic load;
    logic step;
  } drp_ctl_t;

endpackage

@@ design/drp_in_if.sv @@
`timescale 1ns / 1ps
interface drp_in_if;
  import drp_pkg::*;

  logic    valid;
  logic    ready;
  drp_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ design/drp_out_if.sv @@
`timescale 1ns / 1ps
interface drp_out_if;
  import drp_pkg::*;

  logic     valid;
  logic     ready;
  drp_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ design/drp_disc.sv @@
`timescale 1ns / 1ps
module drp_disc (
  input  logic               clk_i,
  input  drp_pkg::drp_ctl_t  ctl_i,
  input  logic signed [31:0] vel_z_i,
  input  logic signed [31:0] height_i,
  output logic signed [63:0] disc_o
);
  import drp_pkg::*;

  logic [63:0] sq_mcand_q;
  logic [31:0] sq_mplr_q;
  logic [63:0] sq_acc_q;
  logic [51:0] gh_mcand_q;
  logic [31:0] gh_mplr_q;
  logic [51:0] gh_acc_q;
  logic        h_neg_q;
  logic [31:0] vz_abs;
  logic [31:0] h_abs;
  logic [63:0] gh_ext;

  assign vz_abs = vel_z_i[31] ? $unsigned(-vel_z_i) : $unsigned(vel_z_i);
  assign h_abs  = height_i[31] ? $unsigned(-height_i) : $unsigned(height_i);

  // Shift-add: one multiplier bit per step for vz^2 and 2g*|h|
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      sq_mcand_q <= {32'b0, vz_abs};
      sq_mplr_q  <= vz_abs;
      sq_acc_q   <= '0;
      gh_mcand_q <= {31'b0, Grav2Q16};
      gh_mplr_q  <= h_abs;
      gh_acc_q   <= '0;
      h_neg_q    <= height_i[31];
    end else if (ctl_i.step) begin
      if (sq_mplr_q[0]) begin
        sq_acc_q <= sq_acc_q + sq_mcand_q;
      end
      if (gh_mplr_q[0]) begin
        gh_acc_q <= gh_acc_q + gh_mcand_q;
      end
      sq_mcand_q <= {sq_mcand_q[62:0], 1'b0};
      sq_mplr_q  <= {1'b0, sq_mplr_q[31:1]};
      gh_mcand_q <= {gh_mcand_q[50:0], 1'b0};
      gh_mplr_q  <= {1'b0, gh_mplr_q[31:1]};
    end
  end

  assign gh_ext = {12'b0, gh_acc_q};
  assign disc_o = $signed(sq_acc_q + (h_neg_q ? (~gh_ext + 64'd1) : gh_ext));

endmodule

@@ design/drp_isqrt.sv @@
`timescale 1ns / 1ps
module drp_isqrt (
  input  logic              clk_i,
  input  drp_pkg::drp_ctl_t ctl_i,
  input  logic [63:0]       rad_i,
  output logic [31:0]       root_o
);
  import drp_pkg::*;

  logic [63:0] rad_q;
  logic [33:0] rem_q;
  logic [31:0] root_q;
  logic [35:0] rem_sh;
  logic [35:0] trial;
  logic [35:0] rem_diff;
  logic        take;

  // Bring in two radicand bits, try root*4+1, keep one root bit
  assign rem_sh   = {rem_q, rad_q[63:62]};
  assign trial    = {2'b00, root_q, 2'b01};
  assign rem_diff = rem_sh - trial;
  assign take     = (rem_sh >= trial);

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (ctl_i.step) begin
      rad_q  <= {rad_q[61:0], 2'b00};
      rem_q  <= take ? rem_diff[33:0] : rem_sh[33:0];
      root_q <= {root_q[30:0], take};
    end
  end

  assign root_o = root_q;

endmodule

@@ design/drp_divmul.sv @@
`timescale 1ns / 1ps
module drp_divmul (
  input  logic               clk_i,
  input  drp_pkg::drp_ctl_t  ctl_i,
  input  logic signed [31:0] vel_z_i,
  input  logic [31:0]        root_i,
  input  logic signed [31:0] vel_x_i,
  input  logic signed [31:0] vel_y_i,
  output logic signed [63:0] prod_x_o,
  output logic signed [63:0] prod_y_o,
  output logic [29:0]        quot_o,
  output logic               neg_o
);
  import drp_pkg::*;

  logic signed [33:0] num;
  logic [33:0]        mag;
  logic signed [32:0] vx_ext;
  logic signed [32:0] vy_ext;
  logic [29:0]        dvd_q;
  logic [19:0]        rem_q;
  logic [29:0]        quot_q;
  logic               neg_q;
  logic signed [32:0] vx_eff_q;
  logic signed [32:0] vy_eff_q;
  logic signed [63:0] acc_x_q;
  logic signed [63:0] acc_y_q;
  logic [20:0]        rem_sh;
  logic [20:0]        rem_diff;
  logic               qb;
  logic signed [63:0] add_x;
  logic signed [63:0] add_y;

  assign num    = $signed({{2{vel_z_i[31]}}, vel_z_i}) + $signed({2'b00, root_i});
  assign mag    = num[33] ? $unsigned(-num) : $unsigned(num);
  assign vx_ext = $signed({vel_x_i[31], vel_x_i});
  assign vy_ext = $signed({vel_y_i[31], vel_y_i});

  // Restoring divide by g, quotient MSB first; each quotient bit feeds
  // both velocity products right away
  assign rem_sh   = {rem_q, dvd_q[29]};
  assign rem_diff = rem_sh - GravQ16;
  assign qb       = (rem_sh >= GravQ16);
  assign add_x    = qb ? 64'(vx_eff_q) : 64'sd0;
  assign add_y    = qb ? 64'(vy_eff_q) : 64'sd0;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      dvd_q    <= {mag[13:0], 16'b0};
      rem_q    <= {1'b0, mag[32:14]};
      quot_q   <= '0;
      neg_q    <= num[33];
      vx_eff_q <= num[33] ? -vx_ext : vx_ext;
      vy_eff_q <= num[33] ? -vy_ext : vy_ext;
      acc_x_q  <= '0;
      acc_y_q  <= '0;
    end else if (ctl_i.step) begin
      dvd_q   <= {dvd_q[28:0], 1'b0};
      rem_q   <= qb ? rem_diff[19:0] : rem_sh[19:0];
      quot_q  <= {quot_q[28:0], qb};
      acc_x_q <= $signed({acc_x_q[62:0], 1'b0}) + add_x;
      acc_y_q <= $signed({acc_y_q[62:0], 1'b0}) + add_y;
    end
  end

  assign prod_x_o = acc_x_q;
  assign prod_y_o = acc_y_q;
  assign quot_o   = quot_q;
  assign neg_o    = neg_q;

endmodule

@@ design/drop_release_predictor_top.sv @@
`timescale 1ns / 1ps
// Samples are taken one at a time: a new one is accepted only once the last has been
//   run through, even while its result still waits in the output register.
// The run is set by the bit-serial units: 32 square steps, 32 root steps, 30 divide steps.
// Reset (rst_ni low, asynchronous) clears the done latch, the sequencer and the
//   output valid, and loads target 0/0 and a miss tolerance of 1.0.
module drop_release_predictor_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [drp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [drp_pkg::CfgDataW-1:0]  cfg_data_i,
  drp_in_if.sink                        in_i,
  drp_out_if.source                     out_o
);
  import drp_pkg::*;

  // Sequencer states
  localparam logic [2:0] StIdle = 3'd0;  // wait for a sample
  localparam logic [2:0] StSq   = 3'd1;  // serial vz^2 + 2g*h
  localparam logic [2:0] StDs   = 3'd2;  // load the root unit with the discriminant
  localparam logic [2:0] StRt   = 3'd3;  // serial square root
  localparam logic [2:0] StDm   = 3'd4;  // form vz + root, load the divider
  localparam logic [2:0] StDv   = 3'd5;  // divide by g and multiply by velocity
  localparam logic [2:0] StMx   = 3'd6;  // form the per-axis miss
  localparam logic [2:0] StFn   = 3'd7;  // compare, write the result beat

  // Configuration
  logic signed [31:0] target_x_q;
  logic signed [31:0] target_y_q;
  logic [30:0]        miss_tol_q;

  // Sequencer
  logic [2:0] state_q, state_d;
  logic [4:0] cnt_q, cnt_d;

  // Sample held for the whole run
  logic signed [31:0] pos_x_q;
  logic signed [31:0] pos_y_q;
  logic signed [31:0] vel_x_q;
  logic signed [31:0] vel_y_q;
  logic signed [31:0] vel_z_q;
  logic               abort_q;

  // Intermediate results
  logic               nosol_q;
  logic signed [32:0] diff_x_q;
  logic signed [32:0] diff_y_q;
  logic signed [48:0] miss_x_q;
  logic signed [48:0] miss_y_q;

  // Output register and done latch
  logic     out_valid_q;
  drp_out_t out_data_q;
  logic     done_q;

  logic               in_fire;
  logic               out_load;
  drp_ctl_t           disc_ctl;
  drp_ctl_t           root_ctl;
  drp_ctl_t           dm_ctl;
  logic signed [63:0] disc;
  logic [31:0]        root;
  logic signed [63:0] prod_x;
  logic signed [63:0] prod_y;
  logic [29:0]        quot;
  logic               t_neg;
  logic signed [48:0] tol_ext;
  logic signed [48:0] tol_neg;
  logic               hit_x;
  logic               hit_y;
  logic               rel;
  logic [23:0]        fall_time;

  // -------------------------------------------------------------------------
  // Configuration writes: unknown indexes are dropped
  // -------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_x_q <= '0;
      target_y_q <= '0;
      miss_tol_q <= MissTolReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgTargetX: target_x_q <= $signed(cfg_data_i);
        CfgTargetY: target_y_q <= $signed(cfg_data_i);
        CfgMissTol: miss_tol_q <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // Handshakes: take a sample only when the sequencer is idle; the result
  // leaves through its own register so a new sample can start while it waits
  // -------------------------------------------------------------------------
  assign in_i.ready = (state_q == StIdle);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_load   = (state_q == StFn) && (!out_valid_q || out_o.ready);

  // -------------------------------------------------------------------------
  // Sequencer: one shared step counter runs each serial phase
  // -------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          state_d = StSq;
          cnt_d   = '0;
        end
      end
      StSq: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == SqLast) begin
          state_d = StDs;
          cnt_d   = '0;
        end
      end
      StDs: state_d = StRt;
      StRt: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == RtLast) begin
          state_d = StDm;
          cnt_d   = '0;
        end
      end
      StDm: state_d = StDv;
      StDv: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == DvLast) begin
          state_d = StMx;
          cnt_d   = '0;
        end
      end
      StMx: state_d = StFn;
      StFn: begin
        if (out_load) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign disc_ctl.load = in_fire;
  assign disc_ctl.step = (state_q == StSq);
  assign root_ctl.load = (state_q == StDs);
  assign root_ctl.step = (state_q == StRt);
  assign dm_ctl.load   = (state_q == StDm);
  assign dm_ctl.step   = (state_q == StDv);

  // -------------------------------------------------------------------------
  // Hold the sample fields that later phases need
  // -------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pos_x_q <= in_i.data.pos_x;
      pos_y_q <= in_i.data.pos_y;
      vel_x_q <= in_i.data.vel_x;
      vel_y_q <= in_i.data.vel_y;
      vel_z_q <= in_i.data.vel_z;
      abort_q <= in_i.data.abort;
    end
  end

  // -------------------------------------------------------------------------
  // Serial datapath
  // -------------------------------------------------------------------------
  // Discriminant D = vz^2 + 2g*h, exact Q32.32
  drp_disc u_disc (
    .clk_i    (clk_i),
    .ctl_i    (disc_ctl),
    .vel_z_i  (in_i.data.vel_z),
    .height_i (in_i.data.height),
    .disc_o   (disc)
  );

  // floor(sqrt(D)) in Q16.16; a negative D still runs but is masked
  drp_isqrt u_isqrt (
    .clk_i  (clk_i),
    .ctl_i  (root_ctl),
    .rad_i  ($unsigned(disc)),
    .root_o (root)
  );

  // t = (vz + root) / g, truncated toward zero, and v * t for both axes
  drp_divmul u_divmul (
    .clk_i    (clk_i),
    .ctl_i    (dm_ctl),
    .vel_z_i  (vel_z_q),
    .root_i   (root),
    .vel_x_i  (vel_x_q),
    .vel_y_i  (vel_y_q),
    .prod_x_o (prod_x),
    .prod_y_o (prod_y),
    .quot_o   (quot),
    .neg_o    (t_neg)
  );

  // Latch the solution flag and the offsets to the target while the discriminant
  // is fresh; the user keeps the configuration put during a run, not enforced by the block
  always_ff @(posedge clk_i) begin
    if (state_q == StDs) begin
      nosol_q  <= disc[63];
      diff_x_q <= $signed({target_x_q[31], target_x_q}) - $signed({pos_x_q[31], pos_x_q});
      diff_y_q <= $signed({target_y_q[31], target_y_q}) - $signed({pos_y_q[31], pos_y_q});
    end
    // Floor v*t to Q16.16 (arithmetic drop of 16 bits) and subtract the offset
    if (state_q == StMx) begin
      miss_x_q <= $signed({prod_x[63], prod_x[63:16]}) - 49'(diff_x_q);
      miss_y_q <= $signed({prod_y[63], prod_y[63:16]}) - 49'(diff_y_q);
    end
  end

  // -------------------------------------------------------------------------
  // Result: |miss| < tol is miss < tol for a positive miss and miss > -tol
  // for a negative one, so no absolute value is formed
  // -------------------------------------------------------------------------
  assign tol_ext = $signed({18'b0, miss_tol_q});
  assign tol_neg = -tol_ext;
  assign hit_x   = miss_x_q[48] ? (miss_x_q > tol_neg) : (miss_x_q < tol_ext);
  assign hit_y   = miss_y_q[48] ? (miss_y_q > tol_neg) : (miss_y_q < tol_ext);
  assign rel     = hit_x && hit_y && !nosol_q && !done_q;

  // Clamp the fall time to Q8.16: zero when there is no solution or t < 0
  always_comb begin
    if (nosol_q || t_neg) begin
      fall_time = '0;
    end else if (|quot[29:24]) begin
      fall_time = FtMax;
    end else begin
      fall_time = quot[23:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q.release_res <= rel;
      out_data_q.fall_time   <= fall_time;
      out_data_q.no_solution <= nosol_q;
      out_data_q.finished    <= done_q;
    end
  end

  // Done latch: set by a release or an abort, cleared only by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
        done_q      <= done_q || rel || abort_q;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> done_q)
    else $error("done latch cleared without reset");

  a_release_sets_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && rel) |=> (done_q && out_valid_q && out_o.data.release_res))
    else $error("release beat did not set the done latch");

  a_accept_starts_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == StSq && cnt_q == 5'd0))
    else $error("accepted beat did not start the square phase");

  a_result_frees_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (in_i.ready && out_valid_q))
    else $error("result beat did not free the input side");

endmodule

@@ tb/drop_release_predictor_top_test.sv @@
`timescale 1ns / 1ps
module drop_release_predictor_top_test;
  import drp_pkg::*;

  // Ballistic constants in Q16.16: g = 9.8 rounded to nearest, and 2 * g
  localparam longint GravFix      = 642253;
  localparam longint GravTwiceFix = 1284506;
  localparam longint FallTimeCap  = 16777215;

  // Index past the last register; the block must ignore a write to it
  localparam logic [CfgIdxW-1:0] CfgSpare = 2'd3;

  localparam int PhaseItems    = 350;
  localparam int LatchedItems  = 330;
  localparam int HoldOffCycles = 700;
  localparam int SettleCycles  = 150;
  localparam int WatchdogLimit = 4000;

  // Everything about one sample that does not depend on the done latch
  typedef struct {
    longint      t;
    logic [23:0] ft;
    bit          nosol;
    bit          hit;
  } fall_sol_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  drp_in_if  in_bus ();
  drp_out_if out_bus ();

  drop_release_predictor_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_bus),
    .out_o      (out_bus)
  );

  // Shadow copy of the registers and of the done latch
  longint target_east = 0, target_north = 0, miss_tol = 65536;
  bit     watch_done = 1'b0;

  drp_in_t  sample_queue[$];    // samples waiting for the driver
  drp_out_t drop_forecasts[$];  // predicted results, oldest first

  int issued_count = 0, taken_count = 0, errors = 0;
  int since_take = 0, send_wait = 0, take_wait = 0;
  int quiet_cycles = 0, hold_left = 0;
  bit in_taken = 1'b0, send_calm = 1'b0, take_calm = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic longint sx(logic [31:0] v);
    return longint'($signed(v));
  endfunction

  // Bit-by-bit floor square root of a 64-bit value
  function automatic longint unsigned sqrt_floor(longint unsigned x);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // Fall time, no-solution flag and the miss test against the current target
  function automatic fall_sol_t solve_fall(drp_in_t s);
    fall_sol_t r;
    longint disc, num, mag, mx, my;
    r.t   = 0;
    r.ft  = '0;
    r.hit = 1'b0;
    // vz^2 + 2*g*h exact in Q32.32
    disc = sx(s.vel_z) * sx(s.vel_z) + GravTwiceFix * sx(s.height);
    r.nosol = (disc < 0);
    if (!r.nosol) begin
      num = sx(s.vel_z) + longint'(sqrt_floor(disc));
      // divide the magnitude, so the quotient rounds toward zero
      mag = ((num < 0 ? -num : num) <<< 16) / GravFix;
      r.t = (num < 0) ? -mag : mag;
      if (r.t > FallTimeCap) r.ft = '1;
      else if (r.t > 0) r.ft = 24'(r.t);
      // landing offset floored to Q16.16, compared with the exact target offset
      mx = ((sx(s.vel_x) * r.t) >>> 16) - (target_east - sx(s.pos_x));
      my = ((sx(s.vel_y) * r.t) >>> 16) - (target_north - sx(s.pos_y));
      r.hit = (mx < 0 ? -mx : mx) < miss_tol && (my < 0 ? -my : my) < miss_tol;
    end
    return r;
  endfunction

  // Expected result of one accepted sample; advances the done latch
  function automatic drp_out_t forecast_drop(drp_in_t s);
    fall_sol_t f;
    drp_out_t  o;
    f = solve_fall(s);
    o.finished    = watch_done;
    o.release_res = f.hit && !watch_done;
    o.fall_time   = f.ft;
    o.no_solution = f.nosol;
    if (o.release_res || s.abort) watch_done = 1'b1;
    return o;
  endfunction

  // Per-item wait, with calm stretches of back-to-back beats
  function automatic int draw_wait(inout bit calm);
    if ($urandom_range(0, 47) == 0) calm = !calm;
    return calm ? 0 : int'($urandom_range(0, 17));
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      4:       return 32'h0000_0001;
      default: return $urandom();
    endcase
  endfunction

  // Miss offset around the tolerance edge, inside it now and then
  function automatic longint pick_miss();
    case ($urandom_range(0, 5))
      0:       return miss_tol;
      1:       return -miss_tol;
      2:       return miss_tol + 1;
      3:       return -miss_tol - 1;
      4:       return longint'($urandom_range(0, 2000)) - 1000;
      default: return miss_tol + longint'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic drp_in_t fix_sample(logic [31:0] px, logic [31:0] py, logic [31:0] h,
                                         logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
                                         logic ab);
    drp_in_t s;
    s.pos_x  = px;
    s.pos_y  = py;
    s.height = h;
    s.vel_x  = vx;
    s.vel_y  = vy;
    s.vel_z  = vz;
    s.abort  = ab;
    return s;
  endfunction

  // Plausible flight state placed so that the landing point sits near the edge
  function automatic drp_in_t near_miss();
    drp_in_t   s;
    fall_sol_t f;
    longint    px, py;
    // height 0..300 m, climb +-30 m/s, ground speed +-60 m/s
    s = fix_sample(0, 0, $urandom_range(0, 19660800),
                   $urandom_range(0, 7864320) - 3932160,
                   $urandom_range(0, 7864320) - 3932160,
                   $urandom_range(0, 3932160) - 1966080, 1'b0);
    f  = solve_fall(s);
    px = target_east - ((sx(s.vel_x) * f.t) >>> 16) + pick_miss();
    py = target_north - ((sx(s.vel_y) * f.t) >>> 16) + pick_miss();
    s.pos_x = px[31:0];
    s.pos_y = py[31:0];
    return s;
  endfunction

  function automatic drp_in_t noise_sample();
    return fix_sample(rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                      rand_word(), 1'(($urandom_range(0, 1))));
  endfunction

  // Before the latch phase: no abort, and turn any would-be hit into a sample
  // with no solution, so the latch stays clear
  function automatic drp_in_t keep_armed(drp_in_t s);
    fall_sol_t f;
    s.abort = 1'b0;
    f = solve_fall(s);
    if (f.hit) begin
      s.vel_z  = '0;
      s.height = 32'h8000_0000;
    end
    return s;
  endfunction

  // Sample right over the target, hovering at 50 m: always a hit
  function automatic drp_in_t dead_on(logic ab);
    return fix_sample(target_east[31:0], target_north[31:0], 32'h0032_0000, 0, 0, 0, ab);
  endfunction

  task automatic offer(drp_in_t s);
    sample_queue = {sample_queue, s};
    issued_count++;
  endtask

  // Wait until every sample is taken and every result has come back
  task automatic drain();
    while (taken_count != issued_count || drop_forecasts.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      CfgTargetX: target_east  = sx(val);
      CfgTargetY: target_north = sx(val);
      CfgMissTol: miss_tol     = longint'({33'b0, val[30:0]});
      default: ;
    endcase
  endtask

  task automatic aim(input logic [31:0] tx, input logic [31:0] ty, input logic [30:0] tol);
    drain();
    write_reg(CfgTargetX, tx);
    write_reg(CfgTargetY, ty);
    write_reg(CfgMissTol, {1'b0, tol});
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic queue_random(input int n, input bit latched);
    drp_in_t s;
    repeat (n) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: s = near_miss();
        6, 7, 8:          s = noise_sample();
        default: begin
          // break a plausible state with a wild height or climb rate
          s        = near_miss();
          s.height = rand_word();
          s.vel_z  = rand_word();
        end
      endcase
      if (latched) s.abort = ($urandom_range(0, 3) == 0);
      else s = keep_armed(s);
      offer(s);
    end
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Driver: hold a beat until taken, then wait the drawn gap and present the next.
  // Count the gap only while the block is ready, or once it has been busy long
  // enough, so gaps land on every phase of its work.
  always @(negedge clk_i) begin
    if (rst_ni && !(in_bus.valid && !in_taken)) begin
      in_taken = 1'b0;
      if (send_wait != 0 && (in_bus.ready || since_take >= 128)) send_wait--;
      if (send_wait == 0 && sample_queue.size() != 0) begin
        in_bus.data  <= sample_queue.pop_front();
        in_bus.valid <= 1'b1;
        send_wait = draw_wait(send_calm);
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // Input monitor: predict on every sample beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_bus.valid && in_bus.ready) begin
        drop_forecasts = {drop_forecasts, forecast_drop(in_bus.data)};
        taken_count++;
        in_taken   = 1'b1;
        since_take = 0;
      end else if (since_take < 1000) begin
        since_take++;
      end
    end
  end

  // Receiver: stall a drawn number of cycles while a result is offered, and
  // drop ready for the whole hold-off
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (take_wait != 0 && out_bus.valid && !out_bus.ready) take_wait--;
      out_bus.ready <= (take_wait == 0) && (hold_left == 0);
    end
  end

  // Hold-off counter, loaded once by the stimulus
  always @(posedge clk_i) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // Output monitor: compare each result beat with the oldest forecast
  always @(posedge clk_i) begin
    drp_out_t got, want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      got       = out_bus.data;
      take_wait = draw_wait(take_calm);
      if (drop_forecasts.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, got %h", $time, got);
        errors++;
      end else begin
        want = drop_forecasts.pop_front();
        check_field("release_res", want.release_res, got.release_res);
        check_field("fall_time", want.fall_time, got.fall_time);
        check_field("no_solution", want.no_solution, got.no_solution);
        check_field("finished", want.finished, got.finished);
      end
    end
  end

  // Watchdog: end the run after too long without any beat
  always @(posedge clk_i) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WatchdogLimit) begin
      $display("drop_release_predictor_top_test: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int base;
    drp_in_t s;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    in_bus.valid  = 1'b0;
    in_bus.data   = '0;
    out_bus.ready = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Poke the unmapped index; the reset target and tolerance must survive it
    write_reg(CfgSpare, $urandom());
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);

    // Directed samples at the reset setting: target at the origin, tolerance 1.0.
    // Offsets of exactly 1.0 sit on the tolerance edge and must not release.
    offer(keep_armed(fix_sample(32'h0001_0000, 0, 0, 0, 0, 0, 1'b0)));
    offer(keep_armed(fix_sample(0, 32'hFFFF_0000, 0, 0, 0, 0, 1'b0)));
    offer(keep_armed(fix_sample(32'h0003_0000, 32'h0003_0000, 0, 0, 0, 0, 1'b0)));
    // every field at its top, then at its bottom (fall time saturates, then goes negative)
    offer(keep_armed(fix_sample('1 >> 1, '1 >> 1, '1 >> 1, '1 >> 1, '1 >> 1, '1 >> 1, 1'b0)));
    offer(keep_armed(fix_sample(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0)));
    // below ground, no vertical speed: negative discriminant
    offer(keep_armed(fix_sample(32'h0005_0000, 0, 32'hFFF6_0000, 0, 0, 0, 1'b0)));
    // below ground while falling: real root, negative fall time
    offer(keep_armed(fix_sample(32'h0032_0000, 0, 32'hFFFF_0000, 32'h0003_0000, 0,
                                32'hFFF6_0000, 1'b0)));
    // fast climb: fall time beyond the output range
    offer(keep_armed(fix_sample(32'h03E8_0000, 0, 32'h0064_0000, 32'h0001_0000, 0,
                                32'h7FFF_FFFF, 1'b0)));
    // smallest height, then smallest sink rate at ground level
    offer(keep_armed(fix_sample(0, 32'h0002_0000, 32'h0000_0001, 0, 0, 0, 1'b0)));
    offer(keep_armed(fix_sample(0, 32'hFFFC_0000, 0, 0, 0, 32'hFFFF_FFFF, 1'b0)));
    // upward throw with mixed horizontal signs
    offer(keep_armed(fix_sample(32'h000A_0000, 32'h000A_0000, 32'h0014_0000, 32'hFFF8_8000,
                                32'h000C_4000, 32'h000F_0000, 1'b0)));
    offer(keep_armed(fix_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'h8000_0000,
                                32'h7FFF_FFFF, 0, 1'b0)));

    // Target in opposite corners, zero tolerance: nothing can ever hit
    aim(32'h7FFF_FFFF, 32'h8000_0000, 31'd0);
    queue_random(PhaseItems, 1'b0);

    // Widest tolerance with a random target: most hits get diverted
    aim($urandom(), $urandom(), 31'h7FFF_FFFF);
    queue_random(PhaseItems, 1'b0);

    // Target within a kilometer, tolerance up to 10 m; stall the result side
    // for a long stretch while samples keep coming
    aim($urandom_range(0, 131072000) - 65536000, $urandom_range(0, 131072000) - 65536000,
        31'($urandom_range(0, 655360)));
    base = taken_count;
    queue_random(PhaseItems, 1'b0);
    while (taken_count < base + 40) @(negedge clk_i);
    hold_left <= HoldOffCycles;

    // Anything goes for target and tolerance
    aim($urandom(), $urandom(), 31'($urandom()));
    queue_random(PhaseItems, 1'b0);

    // Latch phase: the first event that sets the latch, chosen at random among
    // abort together with a hit, abort alone, and a plain hit
    aim(32'h0064_0000, 32'hFFCE_0000, 31'h0002_0000);
    case ($urandom_range(0, 2))
      0: offer(dead_on(1'b1));
      1: begin
        s       = keep_armed(near_miss());
        s.abort = 1'b1;
        offer(s);
      end
      default: offer(dead_on(1'b0));
    endcase
    // already finished: another hit must not release
    offer(dead_on(1'b0));
    queue_random(LatchedItems, 1'b1);

    drain();
    repeat (SettleCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("drop_release_predictor_top_test: clean");
    end else begin
      $display("drop_release_predictor_top_test: errors");
    end
    $finish;
  end

endmodule
